/* hdl/slc_pkg.sv */
`default_nettype none

package slc_pkg;

   localparam int unsigned LINE_KEEP_DEF = 31;
   localparam int unsigned DIGIT_LIMIT   = 9;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned ACC_W  = 30;
   localparam int unsigned CFG_W  = 32;
   localparam int unsigned PROD_W = ACC_W + CFG_W;
   localparam int unsigned READ_W = 31;
   localparam int unsigned CODE_W = 12;

   localparam logic [ACC_W-1:0]  DIGIT_CAP    = ACC_W'(10 ** DIGIT_LIMIT - 1);
   localparam logic [CFG_W-1:0]  SLOPE_RESET  = 32'd269857;
   localparam logic [CFG_W-1:0]  OFFSET_RESET = 32'd3373675336;
   localparam logic [CODE_W-1:0] CODE_MAX     = 12'd4095;
   localparam logic [PROD_W-1:0] OVER_LIMIT   = {(PROD_W-CFG_W)'(4097), CFG_W'(0)};

   localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
   localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
   localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_VT    = 8'h0B;
   localparam logic [BYTE_W-1:0] CH_FF    = 8'h0C;
   localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

   localparam logic CSR_SLOPE  = 1'b0;
   localparam logic CSR_OFFSET = 1'b1;

   typedef enum logic [1:0] {
      PH_LEAD,
      PH_DIGITS,
      PH_DONE
   } phase_type;

   typedef struct packed {
      logic [ACC_W-1:0] mag;
      logic             neg;
      logic             found;
   } line_type;

   typedef struct packed {
      line_type          line;
      logic [PROD_W-1:0] prod;
   } scaled_type;

endpackage

`default_nettype wire

/* hdl/sensor_line_to_dac_code.sv */
// Channel    Direction  Handshake          Payload
// req        in         req_valid/stall    req_rx_byte (8)
// rsp        out        rsp_valid/stall    rsp_dac_code (12), rsp_reading (31),
//                                          rsp_field_found (1), rsp_clipped (1)
// csr        in         csr_write          csr_index (1), csr_wdata (32)
//
// One byte is taken per cycle while req_stall is low; the line parser updates its state in the same cycle.
// A line end reaches rsp_valid through the line register, loaded at the transfer
// edge, then the multiplier register, then the clamp and output register.
// Synchronous reset clears the line state and restores both registers to defaults.
// Three result slots buffer stalls; req_stall rises only when all are full and rsp
// is stalled.
`default_nettype none

module sensor_line_to_dac_code import slc_pkg::*; #(
   parameter int unsigned LINE_KEEP = LINE_KEEP_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [BYTE_W-1:0] req_rx_byte,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [CODE_W-1:0]      rsp_dac_code,
   output logic [READ_W-1:0]      rsp_reading,
   output logic                   rsp_field_found,
   output logic                   rsp_clipped,
   input  wire logic              csr_write,
   input  wire logic              csr_index,
   input  wire logic [CFG_W-1:0]  csr_wdata
);

   logic [CFG_W-1:0] slope_ff, slope_in;
   logic [CFG_W-1:0] offset_ff, offset_in;

   logic             line_valid;
   logic             line_stall;
   line_type         line;
   logic             scaled_valid;
   logic             scaled_stall;
   scaled_type       scaled;

   always_comb begin
      slope_in  = slope_ff;
      offset_in = offset_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_SLOPE:  slope_in  = csr_wdata;
            CSR_OFFSET: offset_in = csr_wdata;
            default:    slope_in  = slope_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slope_ff  <= SLOPE_RESET;
         offset_ff <= OFFSET_RESET;
      end else begin
         slope_ff  <= slope_in;
         offset_ff <= offset_in;
      end
   end

   slc_parser #(
      .LINE_KEEP(LINE_KEEP)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_byte   (req_rx_byte),
      .in_stall  (req_stall),
      .out_valid (line_valid),
      .out_stall (line_stall),
      .out_line  (line)
   );

   slc_mult u_mult (
      .clock     (clock),
      .reset     (reset),
      .slope     (slope_ff),
      .in_valid  (line_valid),
      .in_line   (line),
      .in_stall  (line_stall),
      .out_valid (scaled_valid),
      .out_stall (scaled_stall),
      .out_data  (scaled)
   );

   slc_clamp u_clamp (
      .clock           (clock),
      .reset           (reset),
      .offset          (offset_ff),
      .in_valid        (scaled_valid),
      .in_data         (scaled),
      .in_stall        (scaled_stall),
      .out_valid       (rsp_valid),
      .out_stall       (rsp_stall),
      .out_dac_code    (rsp_dac_code),
      .out_reading     (rsp_reading),
      .out_field_found (rsp_field_found),
      .out_clipped     (rsp_clipped)
   );

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall && scaled_valid && line_valid)
      else $error("input stalled while a result slot was free");

endmodule

`default_nettype wire

/* hdl/slc_parser.sv */
`default_nettype none

module slc_parser import slc_pkg::*; #(
   parameter int unsigned LINE_KEEP = LINE_KEEP_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire logic [BYTE_W-1:0] in_byte,
   output logic                   in_stall,
   output logic                   out_valid,
   input  wire logic              out_stall,
   output line_type               out_line
);

   localparam int unsigned KEEP_W = $clog2(LINE_KEEP + 1);

   logic [KEEP_W-1:0] kept_ff, kept_in;
   logic [1:0]        spaces_ff, spaces_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic              neg_ff, neg_in;
   phase_type         phase_ff, phase_in;
   logic              ended_ff, ended_in;
   logic              line_v_ff, line_v_in;
   line_type          line_ff, line_in;

   logic              accept;
   logic              is_eol;
   logic              keep;
   logic              feed;
   logic              is_digit;
   logic              is_sign;
   logic              is_blank;
   logic              take_digit;
   logic [ACC_W+3:0]  grown;

   assign in_stall  = line_v_ff && out_stall;
   assign out_valid = line_v_ff;
   assign out_line  = line_ff;

   assign accept   = in_valid && !in_stall;
   assign is_eol   = ((in_byte == CH_LF) || (in_byte == CH_CR)) && (kept_ff != '0);
   assign keep     = accept && !is_eol && (kept_ff < KEEP_W'(LINE_KEEP));
   assign feed     = keep && !ended_ff && (in_byte != CH_NUL) && (in_byte != CH_SPACE)
                     && (spaces_ff == 2'd1);
   assign is_digit = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
   assign is_sign  = (in_byte == CH_PLUS) || (in_byte == CH_MINUS);
   assign is_blank = (in_byte == CH_TAB) || (in_byte == CH_LF) || (in_byte == CH_VT)
                     || (in_byte == CH_FF) || (in_byte == CH_CR);

   assign take_digit = feed && is_digit && ((phase_ff == PH_LEAD) || (phase_ff == PH_DIGITS));
   assign grown      = ((ACC_W+4)'(acc_ff) * (ACC_W+4)'(10))
                       + (ACC_W+4)'(in_byte[3:0]);

   always_comb begin
      phase_in = phase_ff;
      if (accept && is_eol) begin
         phase_in = PH_LEAD;
      end else if (feed) begin
         unique case (phase_ff)
            PH_LEAD: begin
               if (is_sign || is_digit) begin
                  phase_in = PH_DIGITS;
               end else if (!is_blank) begin
                  phase_in = PH_DONE;
               end
            end
            PH_DIGITS: begin
               if (!is_digit) begin
                  phase_in = PH_DONE;
               end
            end
            PH_DONE: begin
               phase_in = PH_DONE;
            end
            default: begin
               phase_in = PH_DONE;
            end
         endcase
      end
   end

   always_comb begin
      kept_in   = kept_ff;
      spaces_in = spaces_ff;
      ended_in  = ended_ff;
      acc_in    = acc_ff;
      neg_in    = neg_ff;
      if (accept && is_eol) begin
         kept_in   = '0;
         spaces_in = '0;
         ended_in  = 1'b0;
         acc_in    = '0;
         neg_in    = 1'b0;
      end else if (keep) begin
         kept_in = kept_ff + KEEP_W'(1);
         if (!ended_ff && (in_byte == CH_NUL)) begin
            ended_in = 1'b1;
         end
         if (!ended_ff && (in_byte == CH_SPACE) && (spaces_ff != 2'd2)) begin
            spaces_in = spaces_ff + 2'd1;
         end
         if (take_digit) begin
            acc_in = (grown > (ACC_W+4)'(DIGIT_CAP)) ? DIGIT_CAP : grown[ACC_W-1:0];
         end
         if (feed && is_sign && (phase_ff == PH_LEAD)) begin
            neg_in = (in_byte == CH_MINUS);
         end
      end
   end

   always_comb begin
      line_v_in     = line_v_ff && out_stall;
      line_in       = line_ff;
      if (accept && is_eol) begin
         line_v_in     = 1'b1;
         line_in.found = (spaces_ff == 2'd2);
         line_in.mag   = (spaces_ff == 2'd2) ? acc_ff : '0;
         line_in.neg   = (spaces_ff == 2'd2) && neg_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kept_ff   <= '0;
         spaces_ff <= '0;
         acc_ff    <= '0;
         neg_ff    <= 1'b0;
         phase_ff  <= PH_LEAD;
         ended_ff  <= 1'b0;
         line_v_ff <= 1'b0;
      end else begin
         kept_ff   <= kept_in;
         spaces_ff <= spaces_in;
         acc_ff    <= acc_in;
         neg_ff    <= neg_in;
         phase_ff  <= phase_in;
         ended_ff  <= ended_in;
         line_v_ff <= line_v_in;
      end
   end

   always_ff @(posedge clock) begin
      line_ff <= line_in;
   end

   a_kept_bound: assert property (@(posedge clock) disable iff (reset)
      kept_ff <= KEEP_W'(LINE_KEEP))
      else $error("kept byte count ran past the line limit");

   a_acc_bound: assert property (@(posedge clock) disable iff (reset)
      acc_ff <= DIGIT_CAP)
      else $error("accumulated magnitude exceeds the digit cap");

endmodule

`default_nettype wire

/* hdl/slc_mult.sv */
`default_nettype none

module slc_mult import slc_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [CFG_W-1:0] slope,
   input  wire logic             in_valid,
   input  line_type              in_line,
   output logic                  in_stall,
   output logic                  out_valid,
   input  wire logic             out_stall,
   output scaled_type            out_data
);

   logic       v_ff, v_in;
   scaled_type data_ff, data_in;
   logic       load;

   assign in_stall  = v_ff && out_stall;
   assign load      = in_valid && !in_stall;
   assign out_valid = v_ff;
   assign out_data  = data_ff;

   always_comb begin
      v_in    = load || (v_ff && out_stall);
      data_in = data_ff;
      if (load) begin
         data_in.line = in_line;
         data_in.prod = PROD_W'(in_line.mag) * PROD_W'(slope);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

`default_nettype wire

/* hdl/slc_clamp.sv */
`default_nettype none

module slc_clamp import slc_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [CFG_W-1:0] offset,
   input  wire logic             in_valid,
   input  scaled_type            in_data,
   output logic                  in_stall,
   output logic                  out_valid,
   input  wire logic             out_stall,
   output logic [CODE_W-1:0]     out_dac_code,
   output logic [READ_W-1:0]     out_reading,
   output logic                  out_field_found,
   output logic                  out_clipped
);

   logic                    v_ff, v_in;
   logic [CODE_W-1:0]       code_ff, code_in;
   logic [READ_W-1:0]       reading_ff, reading_in;
   logic                    found_ff, found_in;
   logic                    clip_ff, clip_in;

   logic                    load;
   logic                    over;
   logic                    neg_eff;
   logic [PROD_W:0]         diff;
   logic [PROD_W-CFG_W-1:0] high;
   logic [CODE_W-1:0]       code;
   logic                    clip;

   assign in_stall        = v_ff && out_stall;
   assign load            = in_valid && !in_stall;
   assign out_valid       = v_ff;
   assign out_dac_code    = code_ff;
   assign out_reading     = reading_ff;
   assign out_field_found = found_ff;
   assign out_clipped     = clip_ff;

   assign over    = in_data.prod > OVER_LIMIT;
   assign neg_eff = in_data.line.neg && (in_data.prod != '0);
   assign diff    = {1'b0, in_data.prod} - (PROD_W+1)'(offset);
   assign high    = diff[PROD_W-1:CFG_W];

   always_comb begin
      priority if (neg_eff) begin
         code = '0;
         clip = 1'b1;
      end else if (over) begin
         code = CODE_MAX;
         clip = 1'b1;
      end else if (diff[PROD_W]) begin
         code = '0;
         clip = 1'b1;
      end else if (high > (PROD_W-CFG_W)'(CODE_MAX)) begin
         code = CODE_MAX;
         clip = 1'b1;
      end else begin
         code = high[CODE_W-1:0];
         clip = 1'b0;
      end
   end

   always_comb begin
      v_in       = load || (v_ff && out_stall);
      code_in    = code_ff;
      reading_in = reading_ff;
      found_in   = found_ff;
      clip_in    = clip_ff;
      if (load) begin
         code_in    = code;
         clip_in    = clip;
         found_in   = in_data.line.found;
         reading_in = in_data.line.neg ? (READ_W'(0) - READ_W'(in_data.line.mag))
                                       : READ_W'(in_data.line.mag);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff    <= code_in;
      reading_ff <= reading_in;
      found_ff   <= found_in;
      clip_ff    <= clip_in;
   end

   a_neg_code_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid && out_reading[READ_W-1] |-> out_dac_code == '0)
      else $error("negative reading produced a nonzero code");

   a_missing_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_field_found |-> out_reading == '0)
      else $error("missing field produced a nonzero reading");

endmodule

`default_nettype wire
